/* hw/rtl/bfap_pkg.sv */
// package for the best-fit arena planner: types, constants, state codes
package bfap_pkg;

  localparam int MaxSegs    = 64;
  localparam int MaxHandles = 256;
  localparam int SegAw      = $clog2(MaxSegs);
  localparam int HndAw      = $clog2(MaxHandles);
  localparam int SegCw      = $clog2(MaxSegs + 1);
  localparam int HndCw      = $clog2(MaxHandles + 1);
  localparam int OffW       = 40;
  localparam int SegW       = OffW + OffW + 1;
  localparam logic [40:0] Mask40 = 41'h0FFFFFFFFFF;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StRange    = 3'd1;
  localparam logic [2:0] StDouble   = 3'd2;
  localparam logic [2:0] StNotFound = 3'd3;
  localparam logic [2:0] StFull     = 3'd4;
  localparam logic [2:0] StOverflow = 3'd5;

  localparam logic ActAlloc = 1'b0;
  localparam logic ActFree  = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] req_size;
    logic [7:0]  free_handle;
  } in_word_t;

  typedef struct packed {
    logic [39:0] alloc_offset;
    logic [7:0]  new_handle;
    logic [39:0] arena_total;
    logic [2:0]  status;
  } out_word_t;

  typedef struct packed {
    logic        used;
    logic [39:0] offset;
    logic [39:0] length;
  } seg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DIV, S_SCAN_RD, S_SCAN, S_DECIDE, S_SHIFT_RD, S_SHIFT_WR,
    S_PUT, S_HND_RD, S_HND, S_FIN, S_FREE_RD, S_FREE_SCAN, S_FREE_PREV_RD,
    S_FREE_PREV, S_REM_RD, S_REM_WR, S_OUT
  } state_t;

endpackage

/* hw/rtl/bfap_ram.sv */
// generic single-port write, single-port registered read memory
module bfap_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/best_fit_arena_planner.sv */
// top level of the best-fit arena planner: sequencer, segment and handle memories
//
// One word at a time. An allocate first rounds the size up to the alignment (one
// restoring-division bit per cycle), then scans every segment for the best fit,
// then moves each later segment on a split, or bumps the offset of each later
// segment and of each issued handle above it when a segment is widened; a free
// scans the segments up to the match, and moves each later segment down when it
// merges with the free segment before it. The steps run one after another, as
// each memory has a single read port. No clearing pass is needed after reset.
// The result is held in an output register and the block is ready again as soon
// as the result has moved into it.
module best_fit_arena_planner (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bfap_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bfap_pkg::out_word_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import bfap_pkg::*;

  state_t state_r, state_nxt;
  logic [16:0] align_r;
  logic [SegCw-1:0] seg_cnt_r, seg_cnt_nxt;
  logic [HndCw-1:0] hnd_cnt_r, hnd_cnt_nxt;
  logic [39:0] arena_r, arena_nxt;
  in_word_t req_r, req_nxt;
  out_word_t out_r, out_nxt;
  out_word_t res_r, res_nxt;
  logic out_v_r, out_v_nxt;

  logic [SegCw-1:0] i_r, i_nxt;
  logic [HndCw-1:0] h_r, h_nxt;
  logic [5:0] dcnt_r, dcnt_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [40:0] size_r, size_nxt;
  logic have_best_r, have_best_nxt, have_max_r, have_max_nxt;
  logic [SegAw-1:0] best_r, best_nxt, maxi_r, maxi_nxt;
  logic [39:0] best_len_r, best_len_nxt, max_len_r, max_len_nxt;
  seg_t hold_r, hold_nxt;
  logic [39:0] val_r, val_nxt;
  logic [40:0] expand_r, expand_nxt;
  logic [39:0] off_r, off_nxt;

  logic seg_we;
  logic [SegAw-1:0] seg_wa, seg_ra;
  seg_t seg_wd, seg_rd;
  logic hnd_we;
  logic [HndAw-1:0] hnd_wa, hnd_ra;
  logic [39:0] hnd_wd, hnd_rd;

  bfap_ram #(.Width(SegW), .Depth(MaxSegs)) u_seg (
    .clk(clk), .we(seg_we), .waddr(seg_wa), .wdata(seg_wd),
    .raddr(seg_ra), .rdata(seg_rd)
  );
  bfap_ram #(.Width(OffW), .Depth(MaxHandles)) u_hnd (
    .clk(clk), .we(hnd_we), .waddr(hnd_wa), .wdata(hnd_wd),
    .raddr(hnd_ra), .rdata(hnd_rd)
  );

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {15'd0, align_r} : 32'd0;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_v_r;
  assign out_data = out_r;

  logic [16:0] align_eff;
  logic [33:0] dsub;
  logic [40:0] sum;
  assign align_eff = (align_r == 17'd0) ? 17'd1 : align_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      align_r <= 17'd512;
      seg_cnt_r <= '0;
      hnd_cnt_r <= '0;
      arena_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      seg_cnt_r <= seg_cnt_nxt;
      hnd_cnt_r <= hnd_cnt_nxt;
      arena_r <= arena_nxt;
      out_v_r <= out_v_nxt;
      if (psel && penable && pwrite && paddr[2] == 1'b0) begin
        align_r <= pwdata[16:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    out_r <= out_nxt;
    res_r <= res_nxt;
    i_r <= i_nxt;
    h_r <= h_nxt;
    dcnt_r <= dcnt_nxt;
    rem_r <= rem_nxt;
    size_r <= size_nxt;
    have_best_r <= have_best_nxt;
    have_max_r <= have_max_nxt;
    best_r <= best_nxt;
    maxi_r <= maxi_nxt;
    best_len_r <= best_len_nxt;
    max_len_r <= max_len_nxt;
    hold_r <= hold_nxt;
    val_r <= val_nxt;
    expand_r <= expand_nxt;
    off_r <= off_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    seg_cnt_nxt = seg_cnt_r;
    hnd_cnt_nxt = hnd_cnt_r;
    arena_nxt = arena_r;
    out_v_nxt = out_v_r;
    req_nxt = req_r;
    out_nxt = out_r;
    res_nxt = res_r;
    i_nxt = i_r;
    h_nxt = h_r;
    dcnt_nxt = dcnt_r;
    rem_nxt = rem_r;
    size_nxt = size_r;
    have_best_nxt = have_best_r;
    have_max_nxt = have_max_r;
    best_nxt = best_r;
    maxi_nxt = maxi_r;
    best_len_nxt = best_len_r;
    max_len_nxt = max_len_r;
    hold_nxt = hold_r;
    val_nxt = val_r;
    expand_nxt = expand_r;
    off_nxt = off_r;
    seg_we = 1'b0;
    seg_wa = i_r[SegAw-1:0];
    seg_wd = hold_r;
    seg_ra = i_r[SegAw-1:0];
    hnd_we = 1'b0;
    hnd_wa = h_r[HndAw-1:0];
    hnd_wd = val_r;
    hnd_ra = h_r[HndAw-1:0];
    dsub = {rem_r, req_r.req_size[31]} - {17'd0, align_eff};
    sum = {1'b0, arena_r} + expand_r;

    if (out_v_r && out_ready) begin
      out_v_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data;
          res_nxt = '0;
          i_nxt = '0;
          rem_nxt = '0;
          dcnt_nxt = 6'd32;
          if (in_data.action == ActFree) begin
            h_nxt = {1'b0, in_data.free_handle};
            hnd_ra = in_data.free_handle;
            if ({1'b0, in_data.free_handle} >= hnd_cnt_r) begin
              res_nxt.status = StRange;
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_FREE_RD;
            end
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      // remainder of req_size by alignment, one bit per cycle, then the rounded-up size
      S_DIV: begin
        if (dcnt_r == 6'd0) begin
          if (rem_r == 33'd0) begin
            size_nxt = {9'd0, req_r.req_size};
          end else begin
            size_nxt = {9'd0, req_r.req_size} + {24'd0, align_eff} - {8'd0, rem_r};
          end
          have_best_nxt = 1'b0;
          have_max_nxt = 1'b0;
          if (hnd_cnt_r >= HndCw'(MaxHandles)) begin
            res_nxt.status = StFull;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_SCAN_RD;
          end
        end else begin
          dcnt_nxt = dcnt_r - 6'd1;
          if (!dsub[33]) begin
            rem_nxt = dsub[32:0];
          end else begin
            rem_nxt = {rem_r[31:0], req_r.req_size[31]};
          end
          req_nxt.req_size = {req_r.req_size[30:0], req_r.req_size[31]};
        end
      end
      S_SCAN_RD: begin
        if (i_r >= seg_cnt_r) begin
          state_nxt = S_DECIDE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!seg_rd.used) begin
          if (!have_max_r || seg_rd.length > max_len_r) begin
            have_max_nxt = 1'b1;
            maxi_nxt = i_r[SegAw-1:0];
            max_len_nxt = seg_rd.length;
          end
          if ({1'b0, seg_rd.length} >= size_r &&
              (!have_best_r || seg_rd.length < best_len_r)) begin
            have_best_nxt = 1'b1;
            best_nxt = i_r[SegAw-1:0];
            best_len_nxt = seg_rd.length;
          end
        end
        i_nxt = i_r + 1'b1;
        state_nxt = S_SCAN_RD;
      end
      S_DECIDE: begin
        if (have_best_r) begin
          expand_nxt = {1'b0, best_len_r} - size_r;
          if (best_len_r != size_r[39:0] && seg_cnt_r >= SegCw'(MaxSegs)) begin
            res_nxt.status = StFull;
            state_nxt = S_OUT;
          end else begin
            i_nxt = SegCw'(best_r);
            seg_ra = best_r;
            state_nxt = S_PUT;
          end
        end else if (have_max_r) begin
          expand_nxt = size_r - {1'b0, max_len_r};
          if ({1'b0, arena_r} + size_r - {1'b0, max_len_r} > Mask40) begin
            res_nxt.status = StOverflow;
            state_nxt = S_OUT;
          end else begin
            i_nxt = SegCw'(maxi_r);
            seg_ra = maxi_r;
            state_nxt = S_PUT;
          end
        end else begin
          expand_nxt = size_r;
          if (seg_cnt_r >= SegCw'(MaxSegs)) begin
            res_nxt.status = StFull;
            state_nxt = S_OUT;
          end else if ({1'b0, arena_r} + size_r > Mask40) begin
            res_nxt.status = StOverflow;
            state_nxt = S_OUT;
          end else begin
            off_nxt = arena_r;
            seg_we = 1'b1;
            seg_wa = seg_cnt_r[SegAw-1:0];
            seg_wd = '{used: 1'b1, offset: arena_r, length: size_r[39:0]};
            seg_cnt_nxt = seg_cnt_r + 1'b1;
            arena_nxt = arena_r + size_r[39:0];
            state_nxt = S_FIN;
          end
        end
      end
      // rewrite the chosen segment as used
      S_PUT: begin
        off_nxt = seg_rd.offset;
        seg_we = 1'b1;
        seg_wd = '{used: 1'b1, offset: seg_rd.offset, length: size_r[39:0]};
        if (have_best_r) begin
          if (expand_r == 41'd0) begin
            state_nxt = S_FIN;
          end else begin
            hold_nxt = '{used: 1'b0, offset: seg_rd.offset + size_r[39:0],
                         length: expand_r[39:0]};
            i_nxt = i_r + 1'b1;
            state_nxt = S_SHIFT_RD;
          end
        end else begin
          arena_nxt = sum[39:0];
          i_nxt = i_r + 1'b1;
          state_nxt = S_SHIFT_RD;
        end
      end
      // insertion ripple for a split, offset bump for a widen
      S_SHIFT_RD: begin
        if (i_r >= seg_cnt_r) begin
          if (have_best_r) begin
            seg_we = 1'b1;
            seg_cnt_nxt = seg_cnt_r + 1'b1;
            state_nxt = S_FIN;
          end else begin
            h_nxt = '0;
            state_nxt = S_HND_RD;
          end
        end else begin
          state_nxt = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        seg_we = 1'b1;
        if (have_best_r) begin
          hold_nxt = seg_rd;
        end else begin
          seg_wd = seg_rd;
          seg_wd.offset = seg_rd.offset + expand_r[39:0];
        end
        i_nxt = i_r + 1'b1;
        state_nxt = S_SHIFT_RD;
      end
      S_HND_RD: begin
        if (h_r >= hnd_cnt_r) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_HND;
        end
      end
      S_HND: begin
        if (hnd_rd > off_r) begin
          hnd_we = 1'b1;
          hnd_wd = hnd_rd + expand_r[39:0];
        end
        h_nxt = h_r + 1'b1;
        state_nxt = S_HND_RD;
      end
      S_FIN: begin
        hnd_we = 1'b1;
        hnd_wa = hnd_cnt_r[HndAw-1:0];
        hnd_wd = off_r;
        res_nxt.alloc_offset = off_r;
        res_nxt.new_handle = hnd_cnt_r[7:0];
        res_nxt.status = StOk;
        hnd_cnt_nxt = hnd_cnt_r + 1'b1;
        state_nxt = S_OUT;
      end
      S_FREE_RD: begin
        val_nxt = hnd_rd;
        state_nxt = S_FREE_SCAN;
        i_nxt = '0;
      end
      S_FREE_SCAN: begin
        if (i_r >= seg_cnt_r) begin
          res_nxt.status = StNotFound;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_FREE_PREV_RD;
        end
      end
      S_FREE_PREV_RD: begin
        if (seg_rd.offset == val_r) begin
          if (!seg_rd.used) begin
            res_nxt.status = StDouble;
            state_nxt = S_OUT;
          end else begin
            hold_nxt = seg_rd;
            if (i_r == '0) begin
              seg_we = 1'b1;
              seg_wd = seg_rd;
              seg_wd.used = 1'b0;
              state_nxt = S_OUT;
            end else begin
              seg_ra = i_r[SegAw-1:0] - 1'b1;
              state_nxt = S_FREE_PREV;
            end
          end
        end else begin
          i_nxt = i_r + 1'b1;
          seg_ra = i_r[SegAw-1:0] + 1'b1;
          state_nxt = S_FREE_SCAN;
        end
      end
      S_FREE_PREV: begin
        seg_we = 1'b1;
        if (seg_rd.used) begin
          seg_wd = hold_r;
          seg_wd.used = 1'b0;
          state_nxt = S_OUT;
        end else begin
          seg_wa = i_r[SegAw-1:0] - 1'b1;
          seg_wd = seg_rd;
          seg_wd.length = seg_rd.length + hold_r.length;
          i_nxt = i_r + 1'b1;
          state_nxt = S_REM_RD;
        end
      end
      // close the gap left by the merged segment
      S_REM_RD: begin
        if (i_r >= seg_cnt_r) begin
          seg_cnt_nxt = seg_cnt_r - 1'b1;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_REM_WR;
        end
      end
      S_REM_WR: begin
        seg_we = 1'b1;
        seg_wa = i_r[SegAw-1:0] - 1'b1;
        seg_wd = seg_rd;
        i_nxt = i_r + 1'b1;
        seg_ra = i_r[SegAw-1:0] + 1'b1;
        state_nxt = S_REM_RD;
      end
      S_OUT: begin
        if (!out_v_r || out_ready) begin
          out_nxt = res_r;
          out_nxt.arena_total = arena_r;
          out_v_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
